/* sv/cmtr_pkg.sv */
package cmtr_pkg;

    localparam int BASIC_COLORS = 8;
    localparam int NUM_LETTERS  = 8;

    localparam int CHAR_W      = 8;
    localparam int COL_W       = 8;
    localparam int COLOR_W     = 4;
    localparam int CURSOR_W    = COL_W + 1;
    localparam int MAX_RESULTS = 4;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CASE_MASK = 8'h20;

    localparam logic REG_MAX_COLUMN = 1'b0;
    localparam logic REG_BRIGHT     = 1'b1;

    localparam logic [COL_W-1:0] MAX_COLUMN_RST = 8'd79;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_FORE,
        MODE_BACK,
        MODE_END
    } parse_mode_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_EMIT
    } ctl_state_t;

    typedef logic [CHAR_W-1:0] letter_table_t [NUM_LETTERS];

    localparam letter_table_t COLOR_LETTERS = '{
        8'h6b, 8'h72, 8'h67, 8'h79, 8'h62, 8'h6d, 8'h63, 8'h77
    };

    typedef struct packed {
        logic             accept;
        logic             emit;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count_next;
        logic [IDX_W-1:0] last_idx;
        logic             can_emit;
    } dp_status_t;

    // msb flags a color letter, low bits give the color index
    function automatic logic [COLOR_W:0] color_decode(
        input logic [CHAR_W-1:0] ch,
        input logic              bright
    );
        logic [COLOR_W:0] res;
        res = '0;
        for (int i = 0; i < NUM_LETTERS; i++)
        begin
            if (ch == COLOR_LETTERS[i])
            begin
                res = {1'b1, COLOR_W'(i)};
            end
            if (bright && (ch == (COLOR_LETTERS[i] & ~CASE_MASK)))
            begin
                res = {1'b1, COLOR_W'(BASIC_COLORS + i)};
            end
        end
        return res;
    endfunction

endpackage

/* sv/cmtr_channels.sv */
interface cmtr_msg_if;
    logic                         valid;
    logic                         ready;
    logic [cmtr_pkg::CHAR_W-1:0]  character;
    logic                         first_char;
    logic                         last_char;
    logic [cmtr_pkg::COL_W-1:0]   start_column;

    modport source (output valid, character, first_char, last_char, start_column, input ready);
    modport sink   (input valid, character, first_char, last_char, start_column, output ready);
endinterface

interface cmtr_cell_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [cmtr_pkg::COL_W-1:0]   column;
    logic [cmtr_pkg::CHAR_W-1:0]  glyph;
    logic [cmtr_pkg::COLOR_W-1:0] fore_color;
    logic [cmtr_pkg::COLOR_W-1:0] back_color;
    logic                         final_of_run;

    modport source (output valid, kind, column, glyph, fore_color, back_color, final_of_run,
                    input ready);
    modport sink   (input valid, kind, column, glyph, fore_color, back_color, final_of_run,
                    output ready);
endinterface

/* sv/cmtr_ctrl.sv */
module cmtr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_ready,
    input  cmtr_pkg::dp_status_t status,
    output cmtr_pkg::dp_cmd_t    cmd
);
    import cmtr_pkg::*;

    ctl_state_t       state_reg;
    ctl_state_t       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        msg_ready  = 1'b0;
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    cmd.accept = 1'b1;
                    idx_next   = '0;
                    if (status.count_next != '0)
                    begin
                        state_next = CTL_EMIT;
                    end
                end
            end
            CTL_EMIT:
            begin
                cmd.idx = idx_reg;
                if (status.can_emit)
                begin
                    cmd.emit = 1'b1;
                    if (idx_reg == status.last_idx)
                    begin
                        // last result of the run goes out, next transaction may enter
                        msg_ready  = 1'b1;
                        idx_next   = '0;
                        state_next = CTL_IDLE;
                        if (msg_valid)
                        begin
                            cmd.accept = 1'b1;
                            if (status.count_next != '0)
                            begin
                                state_next = CTL_EMIT;
                            end
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

/* sv/cmtr_datapath.sv */
module cmtr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmtr_pkg::dp_cmd_t             cmd,
    output cmtr_pkg::dp_status_t          status,
    input  logic [cmtr_pkg::COL_W-1:0]    max_column,
    input  logic                          bright_enable,
    input  logic [cmtr_pkg::CHAR_W-1:0]   msg_char,
    input  logic                          msg_first,
    input  logic                          msg_last,
    input  logic [cmtr_pkg::COL_W-1:0]    msg_start,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_kind,
    output logic [cmtr_pkg::COL_W-1:0]    out_column,
    output logic [cmtr_pkg::CHAR_W-1:0]   out_glyph,
    output logic [cmtr_pkg::COLOR_W-1:0]  out_fore,
    output logic [cmtr_pkg::COLOR_W-1:0]  out_back,
    output logic                          out_final
);
    import cmtr_pkg::*;

    parse_mode_t         mode_reg;
    parse_mode_t         mode_next;
    logic                stopped_reg;
    logic                stopped_next;
    logic [CURSOR_W-1:0] cursor_reg;
    logic [CURSOR_W-1:0] cursor_next;
    logic [COLOR_W-1:0]  fore_reg;
    logic [COLOR_W-1:0]  fore_next;
    logic [COLOR_W-1:0]  back_reg;
    logic [COLOR_W-1:0]  back_next;
    logic [CHAR_W-1:0]   letter1_reg;
    logic [CHAR_W-1:0]   letter1_next;
    logic [CHAR_W-1:0]   letter2_reg;
    logic [CHAR_W-1:0]   letter2_next;
    logic [CHAR_W-1:0]   queue_reg [MAX_RESULTS];
    logic [CHAR_W-1:0]   queue_next [MAX_RESULTS];
    logic [COL_W-1:0]    base_reg;
    logic [IDX_W-1:0]    last_idx_reg;
    logic                is_color_reg;
    logic                is_color_next;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [COL_W-1:0]    out_column_reg;
    logic [CHAR_W-1:0]   out_glyph_reg;
    logic [COLOR_W-1:0]  out_fore_reg;
    logic [COLOR_W-1:0]  out_back_reg;
    logic                out_final_reg;

    logic [CURSOR_W-1:0] cursor_start;
    logic                stop_start;
    parse_mode_t         mode_start;
    logic [CHAR_W-1:0]   ch;
    logic [COLOR_W:0]    color;
    logic                color_ok;
    logic                opens;
    logic [CURSOR_W-1:0] avail;
    logic                do_put;
    logic [CNT_W-1:0]    put_len;
    logic [CNT_W-1:0]    print_len;
    logic [CNT_W-1:0]    count;

    always_comb
    begin
        cursor_start = msg_first ? {1'b0, msg_start} : cursor_reg;
        stop_start   = msg_first ? (msg_start > max_column) : stopped_reg;
        mode_start   = msg_first ? MODE_NORMAL : mode_reg;
        ch           = (msg_char == CH_TAB) ? CH_SPACE : msg_char;
        color        = color_decode(ch, bright_enable);
        color_ok     = color[COLOR_W] && !msg_last;
        opens        = !msg_last && (ch == CH_AMP);
        avail        = (cursor_start > {1'b0, max_column}) ? '0 :
                       ({1'b0, max_column} - cursor_start + CURSOR_W'(1));

        mode_next     = mode_start;
        stopped_next  = stop_start;
        cursor_next   = cursor_start;
        fore_next     = fore_reg;
        back_next     = back_reg;
        letter1_next  = letter1_reg;
        letter2_next  = letter2_reg;
        queue_next    = queue_reg;
        is_color_next = 1'b0;
        do_put        = 1'b0;
        put_len       = CNT_W'(1);
        count         = '0;

        if (stop_start)
        begin
            stopped_next = 1'b1;
        end
        else if (msg_char == CH_NL)
        begin
            stopped_next = 1'b1;
            mode_next    = MODE_NORMAL;
        end
        else
        begin
            unique case (mode_start)
                MODE_NORMAL:
                begin
                    do_put        = 1'b1;
                    queue_next[0] = ch;
                end
                MODE_FORE:
                begin
                    if (color_ok)
                    begin
                        fore_next    = color[COLOR_W-1:0];
                        letter1_next = ch;
                        mode_next    = MODE_BACK;
                    end
                    else
                    begin
                        do_put        = 1'b1;
                        put_len       = CNT_W'(2);
                        queue_next[0] = CH_AMP;
                        queue_next[1] = ch;
                    end
                end
                MODE_BACK:
                begin
                    if (color_ok)
                    begin
                        back_next    = color[COLOR_W-1:0];
                        letter2_next = ch;
                        mode_next    = MODE_END;
                    end
                    else
                    begin
                        do_put        = 1'b1;
                        put_len       = CNT_W'(3);
                        queue_next[0] = CH_AMP;
                        queue_next[1] = letter1_reg;
                        queue_next[2] = ch;
                    end
                end
                MODE_END:
                begin
                    if (ch == CH_SEMI)
                    begin
                        is_color_next = 1'b1;
                        count         = CNT_W'(1);
                        mode_next     = MODE_NORMAL;
                    end
                    else
                    begin
                        do_put        = 1'b1;
                        put_len       = CNT_W'(4);
                        queue_next[0] = CH_AMP;
                        queue_next[1] = letter1_reg;
                        queue_next[2] = letter2_reg;
                        queue_next[3] = ch;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase
        end

        // an ampersand before the end of the run opens an escape and prints nothing
        print_len = put_len - CNT_W'(opens);
        if (do_put)
        begin
            count       = (avail >= CURSOR_W'(print_len)) ? print_len : avail[CNT_W-1:0];
            cursor_next = cursor_start + CURSOR_W'(count);
            if (count != print_len)
            begin
                stopped_next = 1'b1;
                mode_next    = MODE_NORMAL;
            end
            else if (opens)
            begin
                mode_next = MODE_FORE;
            end
            else
            begin
                mode_next = MODE_NORMAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            stopped_reg <= 1'b0;
            cursor_reg  <= '0;
            fore_reg    <= '0;
            back_reg    <= '0;
        end
        else if (cmd.accept)
        begin
            mode_reg    <= mode_next;
            stopped_reg <= stopped_next;
            cursor_reg  <= cursor_next;
            fore_reg    <= fore_next;
            back_reg    <= back_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            letter1_reg  <= letter1_next;
            letter2_reg  <= letter2_next;
            queue_reg    <= queue_next;
            base_reg     <= cursor_start[COL_W-1:0];
            last_idx_reg <= IDX_W'(count - CNT_W'(1));
            is_color_reg <= is_color_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg   <= is_color_reg;
            out_column_reg <= is_color_reg ? '0 : base_reg + COL_W'(cmd.idx);
            out_glyph_reg  <= is_color_reg ? '0 : queue_reg[cmd.idx];
            out_fore_reg   <= is_color_reg ? fore_reg : '0;
            out_back_reg   <= is_color_reg ? back_reg : '0;
            out_final_reg  <= (cmd.idx == last_idx_reg);
        end
    end

    assign status.count_next = count;
    assign status.last_idx   = last_idx_reg;
    assign status.can_emit   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_column = out_column_reg;
    assign out_glyph  = out_glyph_reg;
    assign out_fore   = out_fore_reg;
    assign out_back   = out_back_reg;
    assign out_final  = out_final_reg;

endmodule

/* sv/color_markup_text_renderer_unit.sv */
// a result is registered in the queue on acceptance, then in the output register when free
// throughput, with no output stall: one transaction per cycle when it yields at most one
//   result; failed escapes yield up to four, one per cycle via the single output register
// a transaction with no result (escape in progress, stopped, newline) skips the emit state
// reset: rst_n clears parser, cursor, colors and output valid; max_column 79, bright off
module color_markup_text_renderer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    cmtr_msg_if.sink                      msg,
    cmtr_cell_if.source                   cells,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmtr_pkg::PADDR_W-1:0]  paddr,
    input  logic [cmtr_pkg::PDATA_W-1:0]  pwdata,
    output logic [cmtr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import cmtr_pkg::*;

    logic [COL_W-1:0] max_column_reg;
    logic             bright_reg;
    logic             reg_index;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_status_t       status;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_column_reg <= MAX_COLUMN_RST;
            bright_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_MAX_COLUMN: max_column_reg <= pwdata[COL_W-1:0];
                REG_BRIGHT:     bright_reg     <= pwdata[0];
                default:        bright_reg     <= bright_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_MAX_COLUMN: prdata = PDATA_W'(max_column_reg);
            REG_BRIGHT:     prdata = PDATA_W'(bright_reg);
            default:        prdata = '0;
        endcase
    end

    cmtr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg.valid),
        .msg_ready (msg.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cmtr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .max_column    (max_column_reg),
        .bright_enable (bright_reg),
        .msg_char      (msg.character),
        .msg_first     (msg.first_char),
        .msg_last      (msg.last_char),
        .msg_start     (msg.start_column),
        .out_ready     (cells.ready),
        .out_valid     (cells.valid),
        .out_kind      (cells.kind),
        .out_column    (cells.column),
        .out_glyph     (cells.glyph),
        .out_fore      (cells.fore_color),
        .out_back      (cells.back_color),
        .out_final     (cells.final_of_run)
    );

endmodule

/* sv/cmtr_checker.sv */
module cmtr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          kind,
    input logic [cmtr_pkg::COL_W-1:0]    column,
    input logic [cmtr_pkg::CHAR_W-1:0]   glyph,
    input logic [cmtr_pkg::COLOR_W-1:0]  fore_color,
    input logic [cmtr_pkg::COLOR_W-1:0]  back_color,
    input logic                          final_of_run
);
    import cmtr_pkg::*;

    // stalled transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(column)
            && $stable(glyph) && $stable(fore_color) && $stable(back_color)
            && $stable(final_of_run))
        else $error("stalled result changed");

    // a color set is always the only result of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> final_of_run)
        else $error("color set not final");

    // color set carries no cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> column == '0 && glyph == '0)
        else $error("color set with cell fields");

    // put cell carries no colors
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> fore_color == '0 && back_color == '0)
        else $error("put cell with colors");

    // no result during reset
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid in reset");

endmodule

bind color_markup_text_renderer_unit cmtr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (cells.valid),
    .out_ready    (cells.ready),
    .kind         (cells.kind),
    .column       (cells.column),
    .glyph        (cells.glyph),
    .fore_color   (cells.fore_color),
    .back_color   (cells.back_color),
    .final_of_run (cells.final_of_run)
);
